// ===== hw/rtl/cmcg_pkg.sv =====
// ----------------------------------------------------------------------------
// cmcg_pkg
// Shared types and constants of the crosspoint matrix command generator.
// ----------------------------------------------------------------------------
package cmcg_pkg;

   localparam int NUM_MATRIX_OUTPUTS = 16;
   localparam int NUM_MATRIX_INPUTS  = 32;
   localparam int OUT_IDX_W          = $clog2(NUM_MATRIX_OUTPUTS);
   localparam int IN_IDX_W           = $clog2(NUM_MATRIX_INPUTS);
   localparam int PAIR_W             = OUT_IDX_W - 1;
   localparam int HALF_INPUTS        = NUM_MATRIX_INPUTS / 2;
   localparam int POS_W              = $clog2(HALF_INPUTS);
   localparam int CMD_W              = 32;

   localparam logic CHIP_CONNECT = 1'b1;

   typedef enum logic [2:0] {
      OP_CONNECT    = 3'd0,
      OP_DISCONNECT = 3'd1,
      OP_CLEAR_OUT  = 3'd2,
      OP_CLEAR_ALL  = 3'd3,
      OP_QUERY      = 3'd4,
      OP_EMIT       = 3'd5
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   typedef struct packed {
      logic table_op;
      logic emit_accept;
      logic walk_step;
      logic walk_emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic mask_zero;
      logic walk_bit;
      logic walk_last;
   } ctrl_sts_type;

endpackage

// ===== hw/rtl/crosspoint_matrix_command_generator.sv =====
// ----------------------------------------------------------------------------
// crosspoint_matrix_command_generator
// Keeps a 16 x 32 crosspoint connection matrix and turns output pairs into
// 32-bit chip commands.
//
// Requests arrive on the req_ channel (valid/ready); every request gives one
// or more transfers on the rsp_ channel, the final one flagged by rsp_last.
// Table operations (connect, disconnect, clear, query, unused codes) act on
// the rows in the cycle of acceptance (query and unused codes leave them
// unchanged); their single result is in the result register in the next
// cycle. An emit walks the sixteen input positions of its output pair, one
// position per cycle; positions without a connection are skipped without a
// transfer. An emit holds off new requests up to its last connected position
// (at most 16) and through stalls; the next request is taken with the last
// command's transfer. A table request is taken while the previous result is
// being transferred. When rsp_ready is low the result register holds and
// the walk pauses at the next position that carries a command.
// Reset (synchronous) clears all rows, the remembered command and any
// pending result; req_ready stays low while reset is high.
// ----------------------------------------------------------------------------
module crosspoint_matrix_command_generator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_operation,
   input  logic [cmcg_pkg::IN_IDX_W-1:0]      req_input_index,
   input  logic [cmcg_pkg::OUT_IDX_W-1:0]     req_output_index,
   input  logic                               req_exclusive,
   input  logic                               req_allow_split,
   input  logic [cmcg_pkg::PAIR_W-1:0]        req_pair_index,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_ok,
   output logic                               rsp_connected,
   output logic                               rsp_any_connected,
   output logic                               rsp_has_command,
   output logic [cmcg_pkg::CMD_W-1:0]         rsp_command_word,
   output logic                               rsp_last
);

   cmcg_pkg::ctrl_cmd_type cmd;
   cmcg_pkg::ctrl_sts_type sts;

   cmcg_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .sts           (sts),
      .cmd           (cmd)
   );

   cmcg_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_operation),
      .req_input_index   (req_input_index),
      .req_output_index  (req_output_index),
      .req_exclusive     (req_exclusive),
      .req_allow_split   (req_allow_split),
      .req_pair_index    (req_pair_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ok            (rsp_ok),
      .rsp_connected     (rsp_connected),
      .rsp_any_connected (rsp_any_connected),
      .rsp_has_command   (rsp_has_command),
      .rsp_command_word  (rsp_command_word),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== hw/rtl/cmcg_ctrl.sv =====
// ----------------------------------------------------------------------------
// cmcg_ctrl
// Sequencer: takes requests and steps the emit walk over input positions.
// ----------------------------------------------------------------------------
module cmcg_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_operation,
   input  cmcg_pkg::ctrl_sts_type sts,
   output cmcg_pkg::ctrl_cmd_type cmd
);

   cmcg_pkg::state_type state_ff, state_in;
   logic accept;
   logic is_emit;

   assign is_emit = (req_operation == cmcg_pkg::OP_EMIT);
   assign accept  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cmcg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cmcg_pkg::ST_IDLE: begin
            if (accept && is_emit && !sts.mask_zero) begin
               state_in = cmcg_pkg::ST_WALK;
            end
         end
         cmcg_pkg::ST_WALK: begin
            if (sts.walk_bit && sts.slot_free && sts.walk_last) begin
               state_in = cmcg_pkg::ST_IDLE;
            end
         end
         default: state_in = cmcg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      cmd.table_op    = 1'b0;
      cmd.emit_accept = 1'b0;
      cmd.walk_step   = 1'b0;
      cmd.walk_emit   = 1'b0;
      unique case (state_ff)
         cmcg_pkg::ST_IDLE: begin
            req_ready       = sts.slot_free && !reset;
            cmd.table_op    = accept && !is_emit;
            cmd.emit_accept = accept && is_emit;
         end
         cmcg_pkg::ST_WALK: begin
            cmd.walk_emit = sts.walk_bit && sts.slot_free;
            cmd.walk_step = !sts.walk_bit || sts.slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/cmcg_datapath.sv =====
// ----------------------------------------------------------------------------
// cmcg_datapath
// Connection rows, remembered command, emit walk registers and result
// register.
// ----------------------------------------------------------------------------
module cmcg_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cmcg_pkg::ctrl_cmd_type                cmd,
   output cmcg_pkg::ctrl_sts_type                sts,
   input  logic [2:0]                            req_operation,
   input  logic [cmcg_pkg::IN_IDX_W-1:0]         req_input_index,
   input  logic [cmcg_pkg::OUT_IDX_W-1:0]        req_output_index,
   input  logic                                  req_exclusive,
   input  logic                                  req_allow_split,
   input  logic [cmcg_pkg::PAIR_W-1:0]           req_pair_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_ok,
   output logic                                  rsp_connected,
   output logic                                  rsp_any_connected,
   output logic                                  rsp_has_command,
   output logic [cmcg_pkg::CMD_W-1:0]            rsp_command_word,
   output logic                                  rsp_last
);

   localparam int NOUT = cmcg_pkg::NUM_MATRIX_OUTPUTS;
   localparam int NIN  = cmcg_pkg::NUM_MATRIX_INPUTS;
   localparam int HALF = cmcg_pkg::HALF_INPUTS;

   logic [NIN-1:0] rows_ff [NOUT];
   logic [NIN-1:0] rows_in [NOUT];
   logic [cmcg_pkg::CMD_W-1:0] rem_ff, rem_in;

   logic [NIN-1:0] rlo_ff, rlo_in, rhi_ff, rhi_in;
   logic [cmcg_pkg::PAIR_W-1:0] pair_ff, pair_in;
   logic [cmcg_pkg::POS_W-1:0]  pos_ff, pos_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_ok_ff, rsp_ok_in, rsp_conn_ff, rsp_conn_in;
   logic rsp_any_ff, rsp_any_in, rsp_has_ff, rsp_has_in, rsp_last_ff, rsp_last_in;
   logic [cmcg_pkg::CMD_W-1:0] rsp_word_ff, rsp_word_in;

   logic [NIN-1:0]  row_sel, rlo_sel, rhi_sel, bit_mask, row_new;
   logic [HALF-1:0] mask_now, mask_walk;
   logic            conflict, present, any_in;
   logic            op_ok, op_conn, wr_row, clr_all, load;
   logic [7:0]      chip_word;
   logic [cmcg_pkg::CMD_W-1:0] walk_word;

   // Row lookups: every row is decoded at its own place.
   always_comb begin
      row_sel  = '0;
      rlo_sel  = '0;
      rhi_sel  = '0;
      conflict = 1'b0;
      for (int o = 0; o < NOUT; o++) begin
         if (cmcg_pkg::OUT_IDX_W'(o) == req_output_index) begin
            row_sel = row_sel | rows_ff[o];
         end else begin
            conflict = conflict | rows_ff[o][req_input_index];
         end
         if (cmcg_pkg::OUT_IDX_W'(o) == {1'b0, req_pair_index}) begin
            rlo_sel = rlo_sel | rows_ff[o];
         end
         if (cmcg_pkg::OUT_IDX_W'(o) == {1'b1, req_pair_index}) begin
            rhi_sel = rhi_sel | rows_ff[o];
         end
      end
   end

   assign bit_mask = NIN'(1) << req_input_index;
   assign present  = row_sel[req_input_index];
   assign mask_now = rlo_sel[HALF-1:0] | rlo_sel[NIN-1:HALF]
                   | rhi_sel[HALF-1:0] | rhi_sel[NIN-1:HALF];

   always_comb begin
      op_ok   = 1'b0;
      op_conn = 1'b0;
      wr_row  = 1'b0;
      clr_all = 1'b0;
      row_new = row_sel;
      unique case (req_operation)
         cmcg_pkg::OP_CONNECT: begin
            op_ok   = req_allow_split || !conflict;
            wr_row  = op_ok;
            row_new = req_exclusive ? bit_mask : (row_sel | bit_mask);
         end
         cmcg_pkg::OP_DISCONNECT: begin
            op_ok   = present;
            wr_row  = present;
            row_new = row_sel & ~bit_mask;
         end
         cmcg_pkg::OP_CLEAR_OUT: begin
            op_ok   = 1'b1;
            wr_row  = 1'b1;
            row_new = '0;
         end
         cmcg_pkg::OP_CLEAR_ALL: begin
            op_ok   = 1'b1;
            clr_all = 1'b1;
         end
         cmcg_pkg::OP_QUERY: begin
            op_ok   = 1'b1;
            op_conn = present;
         end
         default: begin
            op_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      any_in = 1'b0;
      for (int o = 0; o < NOUT; o++) begin
         rows_in[o] = rows_ff[o];
         if (cmd.table_op) begin
            if (clr_all) begin
               rows_in[o] = '0;
            end else if (wr_row && cmcg_pkg::OUT_IDX_W'(o) == req_output_index) begin
               rows_in[o] = row_new;
            end
         end
         any_in = any_in | (|rows_in[o]);
      end
   end

   // Emit walk: bit 0 of each half is the current input position.
   assign mask_walk = rlo_ff[HALF-1:0] | rlo_ff[NIN-1:HALF]
                    | rhi_ff[HALF-1:0] | rhi_ff[NIN-1:HALF];
   assign chip_word = {cmcg_pkg::CHIP_CONNECT, pair_ff, pos_ff};
   assign walk_word = {rhi_ff[HALF] ? chip_word : rem_ff[31:24],
                       rhi_ff[0]    ? chip_word : rem_ff[23:16],
                       rlo_ff[HALF] ? chip_word : rem_ff[15:8],
                       rlo_ff[0]    ? chip_word : rem_ff[7:0]};

   always_comb begin
      rlo_in  = rlo_ff;
      rhi_in  = rhi_ff;
      pair_in = pair_ff;
      pos_in  = pos_ff;
      rem_in  = rem_ff;
      if (cmd.emit_accept) begin
         rlo_in  = rlo_sel;
         rhi_in  = rhi_sel;
         pair_in = req_pair_index;
         pos_in  = '0;
         if (req_pair_index == '0) begin
            rem_in = '0;
         end
      end else if (cmd.walk_step) begin
         rlo_in = {1'b0, rlo_ff[NIN-1:HALF+1], 1'b0, rlo_ff[HALF-1:1]};
         rhi_in = {1'b0, rhi_ff[NIN-1:HALF+1], 1'b0, rhi_ff[HALF-1:1]};
         pos_in = pos_ff + 1'b1;
      end
      if (cmd.walk_emit) begin
         rem_in = walk_word;
      end
   end

   // Result register
   assign load = cmd.table_op || (cmd.emit_accept && (mask_now == '0)) || cmd.walk_emit;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_conn_in  = rsp_conn_ff;
      rsp_any_in   = rsp_any_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_any_in   = any_in;
         rsp_ok_in    = cmd.table_op ? op_ok : 1'b1;
         rsp_conn_in  = cmd.table_op ? op_conn : 1'b0;
         rsp_has_in   = cmd.walk_emit;
         rsp_word_in  = cmd.walk_emit ? walk_word : '0;
         rsp_last_in  = cmd.walk_emit ? (mask_walk[HALF-1:1] == '0) : 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int o = 0; o < NOUT; o++) begin
            rows_ff[o] <= '0;
         end
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int o = 0; o < NOUT; o++) begin
            rows_ff[o] <= rows_in[o];
         end
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rlo_ff      <= rlo_in;
      rhi_ff      <= rhi_in;
      pair_ff     <= pair_in;
      pos_ff      <= pos_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_conn_ff <= rsp_conn_in;
      rsp_any_ff  <= rsp_any_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign sts.slot_free = !rsp_valid_ff || rsp_ready;
   assign sts.mask_zero = (mask_now == '0);
   assign sts.walk_bit  = mask_walk[0];
   assign sts.walk_last = (mask_walk[HALF-1:1] == '0);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_connected     = rsp_conn_ff;
   assign rsp_any_connected = rsp_any_ff;
   assign rsp_has_command   = rsp_has_ff;
   assign rsp_command_word  = rsp_word_ff;
   assign rsp_last          = rsp_last_ff;

endmodule
